// ===== rtl/twod_pkg.sv =====
// Shared types and constants of the trailing-window outlier detector.
`default_nettype none
package twod_pkg;
    localparam int WINDOW_DEPTH = 256;

    localparam logic [1:0] MODE_AVG = 2'd0;
    localparam logic [1:0] MODE_MIN = 2'd1;
    localparam logic [1:0] MODE_MAX = 2'd2;
    localparam logic [1:0] MODE_OFF = 2'd3;
    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_LESS = 2'd1;
    localparam logic [1:0] REG_SPAN = 2'd2;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_EVRD  = 10'b0000000010,
        S_EVCHK = 10'b0000000100,
        S_MUL   = 10'b0000001000,
        S_CMP   = 10'b0000010000,
        S_OVF   = 10'b0000100000,
        S_PSHRD = 10'b0001000000,
        S_PSHVL = 10'b0010000000,
        S_PSHCK = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    typedef struct packed {
        logic [1:0] mode;
        logic       less;
        logic [31:0] span;
    } t_cfg;
endpackage
`default_nettype wire

// ===== rtl/twod_cfg.sv =====
// Configuration register file of the outlier detector.
`default_nettype none
module twod_cfg (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_addr,
    input  wire logic [31:0]  i_cfg_wdata,
    output twod_pkg::t_cfg    o_cfg
);
    import twod_pkg::*;
    t_cfg r_cfg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_MODE: r_cfg.mode <= i_cfg_wdata[1:0];
                REG_LESS: r_cfg.less <= i_cfg_wdata[0];
                REG_SPAN: r_cfg.span <= i_cfg_wdata;
                default:  r_cfg <= r_cfg;
            endcase
        end
    end
    assign o_cfg = r_cfg;
endmodule
`default_nettype wire

// ===== rtl/trailing_window_outlier_detector_unit.sv =====
// Top level of the trailing-window outlier detector.
// Samples enter on the s_axis channel (restart in tuser, time and value in tdata)
// and one result per sample leaves on m_axis. Configuration is written through
// a plain write port (index 0 mode, 1 direction, 2 span). The user must write
// it only while the block is idle; the block itself does not enforce this.
// One sample at a time is processed by a sequencer around one memory read port
// and one shared 32x9 multiplier and 42-bit comparator. It first evicts the
// entries older than the time span, reading and checking one at a time, then
// multiplies and compares, evicts the oldest entry if the storage is full, pops
// from the tail of the min deque and then of the max deque the entries that the
// new value supersedes, and then stores the sample and registers the result.
// E evictions and P pops can each reach the window size for one sample, but amortized E <= 1 and P <= 2 per sample.
// s_axis_tready is high only while the sequencer is idle. The result sits in
// an output register until taken while the next sample is already processed;
// a stalled receiver holds the sequencer in its last state once that next
// result is ready, so the input stays blocked until the output register frees.
// Reset (synchronous, active low) empties the window, the deques and the hit
// count and clears the configuration; no memory clearing pass is needed.
`default_nettype none
module trailing_window_outlier_detector_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // sample_time[31:0], sample_value[63:32]
    input  wire logic        s_axis_tuser,  // restart
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,  // hit_count[31:0], window_fill[40:32], zero pad
    output logic [1:0]       m_axis_tuser,  // hit[0], overflow[1]
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_wdata
);
    import twod_pkg::*;
    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int FW = $clog2(WINDOW_DEPTH + 1);

    t_cfg cfg;
    twod_cfg u_cfg (.i_clk, .i_rst_n, .i_cfg_we, .i_cfg_addr, .i_cfg_wdata, .o_cfg(cfg));

    // Sample storage and deques of ring positions.
    logic [31:0] time_mem [WINDOW_DEPTH];
    logic signed [31:0] val_mem [WINDOW_DEPTH];
    logic [AW-1:0] min_mem [WINDOW_DEPTH];
    logic [AW-1:0] max_mem [WINDOW_DEPTH];

    t_state r_st;
    logic [AW-1:0] r_head, r_minf, r_maxf;
    logic [FW-1:0] r_fill, r_minc, r_maxc, r_wfill;
    logic signed [40:0] r_sum;
    logic [31:0] r_hits, r_t;
    logic signed [31:0] r_v;
    logic r_hit, r_ovf, r_side; // r_side: 0 min deque, 1 max deque
    logic [31:0] r_rt;
    logic signed [31:0] r_rv;
    logic [AW-1:0] r_rmin, r_rmax;
    logic signed [41:0] r_prod;
    logic r_ov, r_ohit, r_ovf_o;
    logic [31:0] r_ocnt;
    logic [FW-1:0] r_ofill;

    logic [AW-1:0] old_pos, rd_addr, minb, maxb, min_tail, max_tail;
    assign old_pos = AW'(r_head - r_fill[AW-1:0]);
    assign minb = AW'(r_minf + r_minc[AW-1:0]);
    assign maxb = AW'(r_maxf + r_maxc[AW-1:0]);
    assign min_tail = AW'(minb - 1'b1);
    assign max_tail = AW'(maxb - 1'b1);

    // Deque read addresses: front for the aggregate, tail for popping.
    logic [AW-1:0] dq_min_a, dq_max_a;
    assign dq_min_a = (r_st == S_PSHRD) ? min_tail : r_minf;
    assign dq_max_a = (r_st == S_PSHRD) ? max_tail : r_maxf;
    always_ff @(posedge i_clk) begin
        r_rmin <= min_mem[dq_min_a];
        r_rmax <= max_mem[dq_max_a];
    end

    // Sample reads: the oldest entry by default, a deque entry once its
    // position has been read.
    always_comb begin
        rd_addr = old_pos;
        case (r_st)
            S_MUL, S_PSHVL: rd_addr = r_side ? r_rmax : r_rmin;
            default:        rd_addr = old_pos;
        endcase
    end
    always_ff @(posedge i_clk) begin
        r_rt <= time_mem[rd_addr];
        r_rv <= val_mem[rd_addr];
    end

    // Shared arithmetic: one multiply and one compare.
    logic signed [41:0] lhs, rhs;
    logic lt, gt;
    always_comb begin
        lhs = (cfg.mode == MODE_AVG) ? r_prod : 42'(r_v);
        rhs = (cfg.mode == MODE_AVG) ? 42'(r_sum) : 42'(r_rv);
        lt = lhs < rhs;
        gt = lhs > rhs;
    end
    logic evict;
    assign evict = ({1'b0, r_rt} + {1'b0, cfg.span}) < {1'b0, r_t};

    logic accept, out_free;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_st == S_IDLE);
    assign out_free = !r_ov || m_axis_tready;

    logic push_ok, pop_cond;
    assign pop_cond = r_side ? (r_rv <= r_v) : (r_rv >= r_v);
    assign push_ok = r_side ? (r_maxc != '0) : (r_minc != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_head <= '0; r_fill <= '0; r_sum <= '0;
            r_minf <= '0; r_minc <= '0; r_maxf <= '0; r_maxc <= '0;
            r_hits <= '0;
        end else begin
            case (r_st)
                S_IDLE: if (accept) begin
                    r_t <= s_axis_tdata[31:0];
                    r_v <= s_axis_tdata[63:32];
                    r_hit <= 1'b0; r_ovf <= 1'b0;
                    if (s_axis_tuser) begin
                        r_head <= '0; r_fill <= '0; r_sum <= '0; r_hits <= '0;
                        r_minf <= '0; r_minc <= '0; r_maxf <= '0; r_maxc <= '0;
                    end
                    r_st <= S_EVRD;
                end
                S_EVRD: r_st <= (r_fill == '0) ? S_MUL : S_EVCHK;
                S_EVCHK: begin
                    if (evict) begin
                        r_sum <= r_sum - 41'(r_rv);
                        if (r_minc != '0 && r_rmin == old_pos) begin
                            r_minf <= AW'(r_minf + 1'b1); r_minc <= r_minc - 1'b1;
                        end
                        if (r_maxc != '0 && r_rmax == old_pos) begin
                            r_maxf <= AW'(r_maxf + 1'b1); r_maxc <= r_maxc - 1'b1;
                        end
                        r_fill <= r_fill - 1'b1;
                        r_st <= S_EVRD;
                    end else begin
                        r_side <= (cfg.mode == MODE_MAX);
                        r_st <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod <= 42'(r_v) * $signed({1'b0, r_fill});
                    r_wfill <= r_fill;
                    r_st <= S_CMP;
                end
                S_CMP: begin
                    if (r_wfill != '0 && cfg.mode != MODE_OFF && (cfg.less ? lt : gt)) begin
                        r_hit <= 1'b1;
                        if (r_hits != '1) r_hits <= r_hits + 1'b1;
                    end
                    r_st <= S_OVF;
                end
                S_OVF: begin
                    // Full storage: evict the oldest entry (read at S_CMP address).
                    if (r_fill == FW'(WINDOW_DEPTH)) begin
                        r_ovf <= 1'b1;
                        r_sum <= r_sum - 41'(r_rv);
                        if (r_rmin == old_pos) begin
                            r_minf <= AW'(r_minf + 1'b1); r_minc <= r_minc - 1'b1;
                        end
                        if (r_rmax == old_pos) begin
                            r_maxf <= AW'(r_maxf + 1'b1); r_maxc <= r_maxc - 1'b1;
                        end
                        r_fill <= r_fill - 1'b1;
                    end
                    r_side <= 1'b0;
                    r_st <= S_PSHRD;
                end
                S_PSHRD: r_st <= S_PSHVL;
                S_PSHVL: r_st <= S_PSHCK;
                S_PSHCK: begin
                    if (push_ok && pop_cond) begin
                        if (r_side) r_maxc <= r_maxc - 1'b1;
                        else r_minc <= r_minc - 1'b1;
                        r_st <= S_PSHRD;
                    end else if (!r_side) begin
                        r_side <= 1'b1;
                        r_st <= S_PSHRD;
                    end else begin
                        r_st <= S_OUT;
                    end
                end
                S_OUT: if (out_free) begin
                    r_sum <= r_sum + 41'(r_v);
                    r_minc <= r_minc + 1'b1;
                    r_maxc <= r_maxc + 1'b1;
                    r_head <= AW'(r_head + 1'b1);
                    r_fill <= r_fill + 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_st == S_OUT && out_free) begin
            r_ov <= 1'b1;
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_OUT && out_free) begin
            time_mem[r_head] <= r_t;
            val_mem[r_head] <= r_v;
            min_mem[minb] <= r_head;
            max_mem[maxb] <= r_head;
            r_ohit <= r_hit; r_ovf_o <= r_ovf; r_ocnt <= r_hits; r_ofill <= r_wfill;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = {7'd0, 9'(r_ofill), r_ocnt};
    assign m_axis_tuser = {r_ovf_o, r_ohit};
endmodule
`default_nettype wire

// ===== rtl/twod_checker.sv =====
// Port-level checker of the outlier detector, bound to the top level.
`default_nettype none
module twod_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed under stall");
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[40:32] <= 9'd256 && m_axis_tdata[47:41] == 7'd0)
        else $error("window fill out of range");
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[40:32] == 9'd256)
        else $error("overflow with a window that was not full");
    a_hit_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[31:0] != 32'd0)
        else $error("hit with zero count");
endmodule
bind trailing_window_outlier_detector_unit twod_checker u_twod_checker (.*);
`default_nettype wire
